// ----- rtl/core/assert_macros.svh -----
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/jji_pkg.sv -----
package jji_pkg;

  // Joint slots on the ports, and joints actually driven (2..6).
  localparam int NumJoints  = 6;
  localparam int JointCount = 6;
  localparam int JointIdxW  = 3;
  localparam int TargetW    = 16;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;
  localparam logic [CfgIdxW-1:0] CfgXCenter   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgYCenter   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDeadzone  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStickSpd  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWebSpd    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDebounce  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgLimitsLow = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgLimitsHigh = 3'd7;

  // Stick divider: 24-bit dividend, 12-bit divisor, 4 quotient bits per cycle.
  localparam int DivBits    = 24;
  localparam int DivDenW    = 12;
  localparam int DivStep    = 4;
  localparam int DivCycles  = DivBits / DivStep;
  localparam int DivCntW    = $clog2(DivCycles);

  // Web step: (|rate| * web_speed) / 100 = ((p >> 2) * K) >> 23, exact for p < 2^20.
  localparam int WebProdW      = 20;
  localparam int WebQuoW       = 13;
  localparam int WebRecipShift = 23;
  localparam logic [18:0] WebRecipK = 19'd335545;

  localparam logic [1:0] LastPair = 2'd2;

  typedef logic [NumJoints-1:0][TargetW-1:0] target_vec_t;

  typedef struct packed {
    logic [11:0]                x_raw;
    logic [11:0]                y_raw;
    logic                       button;
    logic                       locked;
    logic [NumJoints-1:0][7:0]  jog;
  } in_word_t;

  typedef struct packed {
    logic                 load;
    logic                 stk_mul;
    logic                 div_start;
    logic                 stk_apply;
    logic                 axis;
    logic                 web_mul;
    logic                 web_recip;
    logic                 web_apply;
    logic [JointIdxW-1:0] joint;
    logic                 button;
    logic                 out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage

// ----- rtl/core/jji_divider.sv -----
module jji_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [jji_pkg::DivBits-1:0]  dividend_i,
  input  logic [jji_pkg::DivDenW-1:0]  divisor_i,
  output logic [jji_pkg::DivBits-1:0]  quotient_o,
  output logic                         done_o
);
  import jji_pkg::*;

  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivBits-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW:0]   trial;

  // Restoring division, DivStep quotient bits per cycle.
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int k = 0; k < DivStep; k++) begin
      trial = {rem_d, quo_d[DivBits-1]};
      quo_d = {quo_d[DivBits-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d    = DivDenW'(trial - {1'b0, den_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[DivDenW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivCycles - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = busy_q && (cnt_q == DivCntW'(DivCycles - 1));

endmodule

// ----- rtl/core/jji_datapath.sv -----
module jji_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jji_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [jji_pkg::CfgDataW-1:0]  cfg_data_i,
  input  jji_pkg::in_word_t             in_word_i,
  input  jji_pkg::cmd_t                 cmd_i,
  output jji_pkg::stat_t                stat_o,
  output jji_pkg::target_vec_t          target_o,
  output logic                          stick_active_o,
  output logic                          web_active_o,
  output logic [1:0]                    pair_mode_o
);
  import jji_pkg::*;

  // Configuration registers.
  logic [11:0] x_center_q, y_center_q, deadzone_q, stick_speed_q, web_speed_q;
  logic [15:0] debounce_q;
  logic [NumJoints-1:0][7:0] lim_lo_q, lim_hi_q;

  // Block state.
  target_vec_t tgt_q;
  logic [1:0]  pair_q;
  logic [15:0] press_cnt_q;
  logic        stk_flag_q, web_flag_q;

  // Work registers.
  in_word_t               in_q;
  logic [DivBits-1:0]     stk_prod_q;
  logic                   stk_neg_q, stk_act_q;
  logic [DivDenW-1:0]     div_den_q;
  logic [DivBits-1:0]     stk_quo;
  logic [WebProdW-1:0]    web_prod_q;
  logic [WebQuoW-1:0]     web_quo_q;

  // Result registers.
  target_vec_t out_tgt_q;
  logic        out_stk_q, out_web_q;
  logic [1:0]  out_pair_q;

  // Stick offset for the current axis.
  logic [11:0]        raw, ctr, mag;
  logic signed [12:0] diff;

  // Web rate magnitude for the current joint.
  logic [7:0]  rate, rmag;
  logic [36:0] recip_prod;

  // Shared add and clamp.
  logic [JointIdxW-1:0] idx;
  logic [DivBits-1:0]   step_mag;
  logic                 step_neg, in_range, wr_en;
  logic signed [25:0]   step, sum, lo, hi;
  logic [TargetW-1:0]   clamped;

  // Debounce.
  logic [15:0] cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_center_q    <= 12'd2048;
      y_center_q    <= 12'd2048;
      deadzone_q    <= 12'd100;
      stick_speed_q <= 12'd512;
      web_speed_q   <= 12'd512;
      debounce_q    <= 16'd20;
      lim_lo_q      <= '0;
      lim_hi_q      <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgXCenter:    x_center_q    <= cfg_data_i[11:0];
        CfgYCenter:    y_center_q    <= cfg_data_i[11:0];
        CfgDeadzone:   deadzone_q    <= cfg_data_i[11:0];
        CfgStickSpd:   stick_speed_q <= cfg_data_i[11:0];
        CfgWebSpd:     web_speed_q   <= cfg_data_i[11:0];
        CfgDebounce:   debounce_q    <= cfg_data_i[15:0];
        CfgLimitsLow:  lim_lo_q      <= cfg_data_i;
        CfgLimitsHigh: lim_hi_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_word_i;
    end
  end

  // Stick: |raw - centre| * speed, then divide by centre.
  always_comb begin
    raw  = cmd_i.axis ? in_q.y_raw : in_q.x_raw;
    ctr  = cmd_i.axis ? y_center_q : x_center_q;
    diff = $signed({1'b0, raw}) - $signed({1'b0, ctr});
    mag  = diff[12] ? 12'(-diff) : diff[11:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stk_mul) begin
      stk_prod_q <= mag * stick_speed_q;
      stk_neg_q  <= diff[12];
      stk_act_q  <= mag > deadzone_q;
      div_den_q  <= (ctr == '0) ? 12'd1 : ctr;
    end
  end

  jji_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (stk_prod_q),
    .divisor_i  (div_den_q),
    .quotient_o (stk_quo),
    .done_o     (stat_o.div_done)
  );

  // Web: |rate| * speed, then divide by 100 through the reciprocal.
  assign rate       = in_q.jog[cmd_i.joint];
  assign rmag       = rate[7] ? 8'(-rate) : rate;
  assign recip_prod = 37'(web_prod_q[WebProdW-1:2]) * 37'(WebRecipK);

  always_ff @(posedge clk_i) begin
    if (cmd_i.web_mul) begin
      web_prod_q <= rmag * web_speed_q;
    end
    if (cmd_i.web_recip) begin
      web_quo_q <= recip_prod[WebRecipShift +: WebQuoW];
    end
  end

  // Add the signed step to the target and clamp to the joint limits.
  always_comb begin
    idx      = cmd_i.stk_apply ? {pair_q, cmd_i.axis} : cmd_i.joint;
    step_mag = cmd_i.stk_apply ? stk_quo : DivBits'(web_quo_q);
    step_neg = cmd_i.stk_apply ? stk_neg_q : rate[7];
    step     = step_neg ? -$signed({2'b00, step_mag}) : $signed({2'b00, step_mag});
    sum      = $signed({10'd0, tgt_q[idx]}) + step;
    lo       = $signed({10'd0, lim_lo_q[idx], 8'd0});
    hi       = $signed({10'd0, lim_hi_q[idx], 8'd0});
    if (sum < lo) begin
      clamped = lo[TargetW-1:0];
    end else if (sum > hi) begin
      clamped = hi[TargetW-1:0];
    end else begin
      clamped = sum[TargetW-1:0];
    end
    in_range = idx < JointIdxW'(JointCount);
    wr_en    = in_range &&
               ((cmd_i.stk_apply && stk_act_q && (stk_quo != '0)) ||
                (cmd_i.web_apply && !in_q.locked && (rate != '0)));
  end

  assign cnt_inc = (press_cnt_q == '1) ? press_cnt_q : press_cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q       <= '0;
      pair_q      <= '0;
      press_cnt_q <= '0;
      stk_flag_q  <= 1'b0;
      web_flag_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        stk_flag_q <= 1'b0;
        web_flag_q <= 1'b0;
      end
      if (wr_en) begin
        tgt_q[idx] <= clamped;
        if (cmd_i.stk_apply) begin
          stk_flag_q <= 1'b1;
        end else begin
          web_flag_q <= 1'b1;
        end
      end
      if (cmd_i.button) begin
        if (in_q.button && (cnt_inc > debounce_q)) begin
          press_cnt_q <= '0;
          pair_q      <= (pair_q == LastPair) ? 2'd0 : pair_q + 1'b1;
        end else begin
          press_cnt_q <= cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_tgt_q  <= tgt_q;
      out_stk_q  <= stk_flag_q;
      out_web_q  <= web_flag_q;
      out_pair_q <= pair_q;
    end
  end

  assign target_o       = out_tgt_q;
  assign stick_active_o = out_stk_q;
  assign web_active_o   = out_web_q;
  assign pair_mode_o    = out_pair_q;

endmodule

// ----- rtl/core/jji_ctrl.sv -----
module jji_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  jji_pkg::stat_t stat_i,
  output jji_pkg::cmd_t  cmd_o
);
  import jji_pkg::*;

  typedef enum logic [3:0] {
    StIdle,
    StStkMul,
    StStkDiv,
    StStkWait,
    StStkApply,
    StWebMul,
    StWebRecip,
    StWebApply,
    StButton,
    StFinish
  } state_e;

  state_e               state_q;
  logic                 axis_q;
  logic [JointIdxW-1:0] joint_q;
  logic                 out_valid_q;
  logic                 out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.axis      = axis_q;
    cmd_o.joint     = joint_q;
    cmd_o.load      = (state_q == StIdle) && in_valid_i;
    cmd_o.stk_mul   = (state_q == StStkMul);
    cmd_o.div_start = (state_q == StStkDiv);
    cmd_o.stk_apply = (state_q == StStkApply);
    cmd_o.web_mul   = (state_q == StWebMul);
    cmd_o.web_recip = (state_q == StWebRecip);
    cmd_o.web_apply = (state_q == StWebApply);
    cmd_o.button    = (state_q == StButton);
    cmd_o.out_load  = (state_q == StFinish) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      axis_q      <= 1'b0;
      joint_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result word takes the slot in the same cycle the old one leaves
      if (out_valid_q && out_ready_i && !cmd_o.out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            axis_q  <= 1'b0;
            state_q <= StStkMul;
          end
        end
        StStkMul:  state_q <= StStkDiv;
        StStkDiv:  state_q <= StStkWait;
        StStkWait: begin
          if (stat_i.div_done) begin
            state_q <= StStkApply;
          end
        end
        StStkApply: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= StStkMul;
          end else begin
            joint_q <= '0;
            state_q <= StWebMul;
          end
        end
        StWebMul:   state_q <= StWebRecip;
        StWebRecip: state_q <= StWebApply;
        StWebApply: begin
          if (joint_q == JointIdxW'(JointCount - 1)) begin
            state_q <= StButton;
          end else begin
            joint_q <= joint_q + 1'b1;
            state_q <= StWebMul;
          end
        end
        StButton: state_q <= StFinish;
        StFinish: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- rtl/core/joint_jog_integrator_top.sv -----
// Joint jog integrator. Each input word is one update tick: two 12-bit
// joystick samples, the mode button level, a motion-lock flag and six signed
// web jog rates. The block holds six Q8.8 joint targets. Per tick it first
// steps the selected joint pair by the joystick, (raw - centre) * stick_speed
// / centre per axis once the offset exceeds the deadzone; then, unless
// locked, each nonzero web rate adds rate * web_speed / 100; then a
// debounced button press advances the pair (0 -> 1 -> 2 -> 0). Every step
// truncates toward zero and each moved joint is clamped to its limit bytes
// times 256. One result word per tick carries all six targets, the two
// activity flags and the pair after the tick.
// The joystick divide runs per axis through a shared restoring divider that
// retires 4 quotient bits per cycle. The web steps run one joint at a time
// through a multiply and a reciprocal multiply. A new word is taken only in
// idle, but a finished result sits in its own output register, so the next
// word is accepted while it waits.
// Configuration: cfg_ready_o is always high; write only while idle.
// Register indexes: 0 x_center, 1 y_center, 2 deadzone, 3 stick_speed,
// 4 web_speed, 5 debounce_ticks, 6 limits_low_word, 7 limits_high_word.
// No clearing pass after reset: the block is ready on the first cycle.
module joint_jog_integrator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [jji_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [jji_pkg::CfgDataW-1:0] cfg_data_i,
  // input word channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [11:0]                  x_raw_i,
  input  logic [11:0]                  y_raw_i,
  input  logic                         mode_button_low_i,
  input  logic                         motion_locked_i,
  input  logic signed [7:0]            jog_rate_0_i,
  input  logic signed [7:0]            jog_rate_1_i,
  input  logic signed [7:0]            jog_rate_2_i,
  input  logic signed [7:0]            jog_rate_3_i,
  input  logic signed [7:0]            jog_rate_4_i,
  input  logic signed [7:0]            jog_rate_5_i,
  // result word channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [15:0]                  target_0_o,
  output logic [15:0]                  target_1_o,
  output logic [15:0]                  target_2_o,
  output logic [15:0]                  target_3_o,
  output logic [15:0]                  target_4_o,
  output logic [15:0]                  target_5_o,
  output logic                         stick_active_o,
  output logic                         web_active_o,
  output logic [1:0]                   pair_mode_o
);
  import jji_pkg::*;

  in_word_t    in_word;
  cmd_t        cmd;
  stat_t       stat;
  target_vec_t targets;

  // Registers are plain flops, so cfg_ready_o never holds off a write.
  assign cfg_ready_o = 1'b1;

  // Pack the input word; jog rate k sits in lane k.
  assign in_word.x_raw  = x_raw_i;
  assign in_word.y_raw  = y_raw_i;
  assign in_word.button = mode_button_low_i;
  assign in_word.locked = motion_locked_i;
  assign in_word.jog[0] = jog_rate_0_i;
  assign in_word.jog[1] = jog_rate_1_i;
  assign in_word.jog[2] = jog_rate_2_i;
  assign in_word.jog[3] = jog_rate_3_i;
  assign in_word.jog[4] = jog_rate_4_i;
  assign in_word.jog[5] = jog_rate_5_i;

  // Sequencer: stick X, stick Y, web joints, button, result.
  jji_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Targets, config, multipliers, divider and the shared clamp.
  jji_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_word_i      (in_word),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .target_o       (targets),
    .stick_active_o (stick_active_o),
    .web_active_o   (web_active_o),
    .pair_mode_o    (pair_mode_o)
  );

  assign target_0_o = targets[0];
  assign target_1_o = targets[1];
  assign target_2_o = targets[2];
  assign target_3_o = targets[3];
  assign target_4_o = targets[4];
  assign target_5_o = targets[5];

endmodule

// ----- rtl/core/jji_checker.sv -----
`include "assert_macros.svh"

module jji_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] target_0_o,
  input logic [1:0]  pair_mode_o
);

  // A stalled result word stays offered, with target_0 and the pair unchanged.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NEXT(a_out_tgt_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(target_0_o))
  `ASSERT_NEXT(a_out_pair_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(pair_mode_o))

  // Pair select only cycles through three codes.
  `ASSERT_IMPLIES(a_pair_range, clk_i, rst_ni, out_valid_o, pair_mode_o != 2'd3)

  // One tick at a time: taking a word makes the block busy.
  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind joint_jog_integrator_top jji_checker u_checker (.*);

// ----- tb/tb_joint_jog_integrator_top.sv -----
// Self-checking bench for the joint jog integrator.
// An initial block programs the registers and fills a queue of tick words.
// A clocked driver feeds that queue to the input port, and a clocked monitor
// takes result words. On every accepted tick the driver runs the bench's own
// copy of the integrator and queues the word the block should return.
module tb_joint_jog_integrator_top;
  import jji_pkg::*;

  // One result word: all six targets plus the flags and the pair.
  typedef struct packed {
    target_vec_t tgt;
    logic        stick;
    logic        web;
    logic [1:0]  pair;
  } tick_result_t;

  // Kinds of register setting used per phase.
  typedef enum int {SetAllMin, SetAllMax, SetMixed} reg_set_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  logic     in_valid = 1'b0;
  logic     in_ready;
  in_word_t in_word  = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] target_0, target_1, target_2, target_3, target_4, target_5;
  logic        stick_active, web_active;
  logic [1:0]  pair_mode;

  joint_jog_integrator_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .x_raw_i           (in_word.x_raw),
    .y_raw_i           (in_word.y_raw),
    .mode_button_low_i (in_word.button),
    .motion_locked_i   (in_word.locked),
    .jog_rate_0_i      (in_word.jog[0]),
    .jog_rate_1_i      (in_word.jog[1]),
    .jog_rate_2_i      (in_word.jog[2]),
    .jog_rate_3_i      (in_word.jog[3]),
    .jog_rate_4_i      (in_word.jog[4]),
    .jog_rate_5_i      (in_word.jog[5]),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .target_0_o        (target_0),
    .target_1_o        (target_1),
    .target_2_o        (target_2),
    .target_3_o        (target_3),
    .target_4_o        (target_4),
    .target_5_o        (target_5),
    .stick_active_o    (stick_active),
    .web_active_o      (web_active),
    .pair_mode_o       (pair_mode)
  );

  // Register copies, the scalars kept as signed 64-bit so products and quotients
  // stay signed and truncate toward zero like the hardware.
  longint      x_ctr    = 2048;
  longint      y_ctr    = 2048;
  longint      dz       = 100;
  longint      stk_spd  = 512;
  longint      web_spd  = 512;
  longint      db_ticks = 20;
  logic [47:0] lim_lo   = '0;
  logic [47:0] lim_hi   = '1;

  // Integrator state.
  logic [15:0] joint_pos [6] = '{default: '0};
  logic [1:0]  sel_pair      = '0;
  int          since_press   = 0;

  in_word_t     ticks_to_send [$];
  tick_result_t tick_results  [$];

  int           mismatches = 0;
  int           gap_left   = 0;
  int           stall_left = 0;
  bit           no_idle    = 1'b0;
  tick_result_t seen_word;

  initial forever #6 clk_i = ~clk_i;

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Integrator prediction
  // ---------------------------------------------------------------------

  // Limit bytes are whole positions, i.e. byte * 256 in Q8.8.
  // Crossed limits fall out of the test order: below the lower limit gives it, else the upper.
  function automatic logic [15:0] clamp_joint_pos(int j, longint v);
    longint lo, hi;
    lo = longint'(lim_lo[8*j +: 8]) * 256;
    hi = longint'(lim_hi[8*j +: 8]) * 256;
    if (v < lo) return lo[15:0];
    if (v > hi) return hi[15:0];
    return v[15:0];
  endfunction

  // Offset must strictly exceed the deadzone. A zero centre divides by one.
  function automatic longint axis_step(logic [11:0] raw, longint ctr);
    longint d, mag, div;
    d   = longint'(raw) - ctr;
    mag = (d < 0) ? -d : d;
    div = (ctr == 0) ? 1 : ctr;
    if (mag <= dz) return 0;
    return d * stk_spd / div;
  endfunction

  // One tick: stick on the current pair, then the button, then web jog.
  function automatic tick_result_t integrate_tick(in_word_t w);
    tick_result_t r;
    longint       sx, sy, rate;
    int           ja, jb;
    logic [1:0]   cur;
    r   = '0;
    cur = sel_pair;
    ja  = 2 * cur;
    jb  = ja + 1;
    sx  = axis_step(w.x_raw, x_ctr);
    sy  = axis_step(w.y_raw, y_ctr);
    // a step that truncates to zero leaves the joint alone, unclamped
    if (sx != 0 && ja < JointCount) begin
      joint_pos[ja] = clamp_joint_pos(ja, longint'(joint_pos[ja]) + sx);
      r.stick = 1'b1;
    end
    if (sy != 0 && jb < JointCount) begin
      joint_pos[jb] = clamp_joint_pos(jb, longint'(joint_pos[jb]) + sy);
      r.stick = 1'b1;
    end
    // counter saturates; a press counts only once it exceeds the window
    if (since_press < 65535) since_press++;
    if (w.button && since_press > db_ticks) begin
      since_press = 0;
      sel_pair    = (cur == LastPair) ? 2'd0 : cur + 2'd1;
    end
    // web jog: any nonzero rate clamps its joint, even with a zero step
    if (!w.locked) begin
      for (int j = 0; j < JointCount; j++) begin
        rate = longint'($signed(w.jog[j]));
        if (rate != 0) begin
          r.web        = 1'b1;
          joint_pos[j] = clamp_joint_pos(j, longint'(joint_pos[j]) + rate * web_spd / 100);
        end
      end
    end
    for (int j = 0; j < NumJoints; j++)
      r.tgt[j] = (j < JointCount) ? joint_pos[j] : 16'd0;
    r.pair = sel_pair;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Samples cluster inside, on and just past the deadzone edge.
  function automatic logic [11:0] axis_sample(longint ctr);
    longint v;
    case ($urandom_range(0, 7))
      0, 1:    v = ctr + longint'($urandom_range(0, 2 * dz)) - dz;
      2:       v = $urandom_range(0, 1) ? ctr + dz : ctr - dz;
      3:       v = $urandom_range(0, 1) ? ctr + dz + 1 : ctr - dz - 1;
      4:       v = $urandom_range(0, 1) ? 4095 : 0;
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  function automatic in_word_t random_tick();
    in_word_t w;
    int       k;
    w.x_raw  = axis_sample(x_ctr);
    w.y_raw  = axis_sample(y_ctr);
    w.button = ($urandom_range(0, 2) == 0);
    w.locked = ($urandom_range(0, 4) == 0);
    for (int j = 0; j < NumJoints; j++) begin
      k = $urandom_range(0, 7);
      if (k < 4) w.jog[j] = 8'd0;
      else if (k < 7) w.jog[j] = 8'($urandom_range(0, 200)) - 8'd100;
      else w.jog[j] = 8'($urandom);  // full -128..127
    end
    return w;
  endfunction

  task automatic send(logic [11:0] x, logic [11:0] y, logic btn, logic lock,
                      logic [47:0] jog);
    in_word_t w;
    w.x_raw  = x;
    w.y_raw  = y;
    w.button = btn;
    w.locked = lock;
    w.jog    = jog;
    ticks_to_send.push_back(w);
  endtask

  // One register write; the copy is updated at the accepting edge.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CfgXCenter:    x_ctr    = longint'(val[11:0]);
      CfgYCenter:    y_ctr    = longint'(val[11:0]);
      CfgDeadzone:   dz       = longint'(val[11:0]);
      CfgStickSpd:   stk_spd  = longint'(val[11:0]);
      CfgWebSpd:     web_spd  = longint'(val[11:0]);
      CfgDebounce:   db_ticks = longint'(val[15:0]);
      CfgLimitsLow:  lim_lo   = val[47:0];
      CfgLimitsHigh: lim_hi   = val[47:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CfgDataW-1:0] pick_value(reg_set_e kind,
      logic [CfgDataW-1:0] lo_v, logic [CfgDataW-1:0] hi_v, logic [CfgDataW-1:0] mid_v);
    int r;
    r = $urandom_range(0, 99);
    if (kind == SetAllMin || (kind == SetMixed && r < 12)) return lo_v;
    if (kind == SetAllMax || (kind == SetMixed && r < 24)) return hi_v;
    return mid_v;
  endfunction

  // Writes every register for one phase.
  task automatic program_regs(reg_set_e kind);
    logic [CfgDataW-1:0] ctr_v, dz_v, spd_v, db_v;
    logic [47:0]         lo_w, hi_w;
    logic [7:0]          a, b;
    for (int j = 0; j < NumJoints; j++) begin
      a = 8'($urandom_range(0, 120));
      b = 8'($urandom_range(130, 255));
      case ($urandom_range(0, 9))
        0:       begin lo_w[8*j +: 8] = b; hi_w[8*j +: 8] = a; end  // crossed
        1:       begin lo_w[8*j +: 8] = 8'($urandom); hi_w[8*j +: 8] = 8'($urandom); end
        default: begin lo_w[8*j +: 8] = a; hi_w[8*j +: 8] = b; end
      endcase
    end
    ctr_v = $urandom_range(0, 1) ? $urandom_range(1900, 2200) : $urandom_range(0, 4095);
    write_reg(CfgXCenter, pick_value(kind, 0, 4095, ctr_v));
    ctr_v = $urandom_range(0, 1) ? $urandom_range(1900, 2200) : $urandom_range(0, 4095);
    write_reg(CfgYCenter, pick_value(kind, 0, 4095, ctr_v));
    dz_v = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 200) : $urandom_range(0, 4095);
    write_reg(CfgDeadzone, pick_value(kind, 0, 4095, dz_v));
    spd_v = $urandom_range(0, 1) ? $urandom_range(1, 600) : $urandom_range(0, 4095);
    write_reg(CfgStickSpd, pick_value(kind, 0, 4095, spd_v));
    spd_v = $urandom_range(0, 1) ? $urandom_range(1, 600) : $urandom_range(0, 4095);
    write_reg(CfgWebSpd, pick_value(kind, 0, 4095, spd_v));
    case ($urandom_range(0, 9))
      0:       db_v = $urandom_range(0, 65535);
      1, 2:    db_v = $urandom_range(7, 40);
      default: db_v = $urandom_range(0, 6);  // keep presses landing
    endcase
    write_reg(CfgDebounce, pick_value(kind, 0, 65535, db_v));
    write_reg(CfgLimitsLow, pick_value(kind, '0, 48'hFFFF_FFFF_FFFF, lo_w));
    write_reg(CfgLimitsHigh, pick_value(kind, '0, 48'hFFFF_FFFF_FFFF, hi_w));
  endtask

  // Every tick returns a word, so an empty result queue means idle.
  // Checked on the falling edge, once the driver's updates have settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (ticks_to_send.size() != 0 || in_valid || tick_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Input driver: launches queued ticks, predicts on acceptance
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_word  <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) tick_results.push_back(integrate_tick(in_word));
      // a held word stays put until taken; the gap runs after each launch
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (ticks_to_send.size() != 0) begin
          in_word  <= ticks_to_send.pop_front();
          in_valid <= 1'b1;
          gap_left <= idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: random back-pressure, field-by-field compare
  // ---------------------------------------------------------------------
  function automatic void flag_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        seen_word.tgt   = {target_5, target_4, target_3, target_2, target_1, target_0};
        seen_word.stick = stick_active;
        seen_word.web   = web_active;
        seen_word.pair  = pair_mode;
        if (tick_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, seen_word);
          mismatches++;
        end else begin
          tick_result_t want;
          want = tick_results.pop_front();
          for (int j = 0; j < NumJoints; j++)
            flag_field($sformatf("target_%0d", j), want.tgt[j], seen_word.tgt[j]);
          flag_field("stick_active", 16'(want.stick), 16'(seen_word.stick));
          flag_field("web_active", 16'(want.web), 16'(seen_word.web));
          flag_field("pair_mode", 16'(want.pair), 16'(seen_word.pair));
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left <= idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: centres 2048, deadzone 100, speeds 512, window 20.
    send(2048, 2048, 0, 0, '0);                      // at rest
    send(2148, 1948, 0, 0, '0);                      // offset equals deadzone
    send(2149, 1947, 0, 0, '0);                      // just past it; joint 1 clamps low
    send(4095, 4095, 0, 0, '0);                      // full deflection up
    send(0, 0, 0, 0, '0);                            // full deflection down
    send(2048, 2048, 0, 0, {6{8'd100}});             // full web rate
    send(2048, 2048, 0, 0, {6{8'h9C}});              // -100 on all joints
    send(2048, 2048, 0, 0, {3{8'h80, 8'h7F}});       // rates beyond +-100
    send(2048, 2048, 0, 1, {6{8'd50}});              // locked: web ignored
    send(4095, 0, 1, 1, {6{8'd1}});                  // press inside the window
    wait_drained();

    // Zero x centre, tiny speeds, no window, joint 1 with crossed limits.
    write_reg(CfgXCenter, 0);
    write_reg(CfgYCenter, 4095);
    write_reg(CfgDeadzone, 0);
    write_reg(CfgStickSpd, 1);
    write_reg(CfgWebSpd, 1);
    write_reg(CfgDebounce, 0);
    write_reg(CfgLimitsLow, 48'h0000_0000_8000);
    write_reg(CfgLimitsHigh, 48'hFFFF_FFFF_10FF);
    send(5, 4094, 0, 0, '0);                         // divide by one; y step truncates to 0
    send(0, 4095, 0, 0, 48'h0000_0000_0100);         // zero web step still clamps joint 1
    send(0, 4095, 1, 0, '0);                         // press: pair 1
    send(4095, 0, 1, 0, '0);                         // joints 2/3 move, pair 2
    send(4095, 0, 1, 0, '0);                         // joints 4/5 move, pair wraps
    send(1, 4095, 1, 1, 48'hFFFF_FFFF_FFFF);         // locked, press to pair 1
    wait_drained();

    // Random phases: both extremes first, then mixed settings.
    // Every fourth phase runs with no idling on either side.
    for (int p = 0; p < 12; p++) begin
      no_idle = (p % 4 == 3);
      program_regs(p == 0 ? SetAllMin : (p == 1 ? SetAllMax : SetMixed));
      repeat (140) ticks_to_send.push_back(random_tick());
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
